/* src/tbw_pkg.sv */
// ----------------------------------------------------------------------------
// tbw_pkg: shared constants for the transmit byte buffer
// Operation codes, buffer sizing and decimal formatting constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tbw_pkg;

   // operation codes carried in req_tuser
   localparam logic [2:0] OP_WRITE_CHAR  = 3'd0;
   localparam logic [2:0] OP_WRITE_NUM10 = 3'd1;
   localparam logic [2:0] OP_WRITE_NUM3  = 3'd2;
   localparam logic [2:0] OP_WRITE_NUM2  = 3'd3;
   localparam logic [2:0] OP_TICK        = 3'd4;

   // default buffer depth in bytes
   localparam int BUFFER_DEPTH_DEF = 2048;

   // decimal formatting
   localparam logic [7:0]  ASCII_ZERO = 8'd48;
   localparam logic [31:0] NUM3_MAX   = 32'd999;
   localparam logic [31:0] NUM2_MAX   = 32'd99;

   // position of the most significant digit written, per number width
   localparam logic [3:0] TOP_POS_NUM10 = 4'd9;
   localparam logic [3:0] TOP_POS_NUM3  = 4'd2;
   localparam logic [3:0] TOP_POS_NUM2  = 4'd1;

   // binary to BCD converter: bits consumed per cycle and cycle count
   localparam int CONV_BITS_PER_CYCLE = 4;
   localparam int CONV_CYCLES         = 32 / CONV_BITS_PER_CYCLE;

endpackage

`default_nettype wire

/* src/tx_byte_buffer_with_decimal_writer_core.sv */
// ----------------------------------------------------------------------------
// tx_byte_buffer_with_decimal_writer_core
// Linear transmit byte buffer with a fixed-width ASCII decimal writer.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one beat per command. req_tuser selects the operation
//    (write char, write 10/3/2-digit number, tick). Characters and digits
//    are appended to a linear byte store; a byte is dropped when the store
//    is full. Numbers above the range of a 3- or 2-digit write add nothing.
//  - rsp_ channel: a tick with a byte pending returns that byte as one beat.
//    A tick with nothing pending returns nothing and rewinds the store.
//  - A char write completes on acceptance; a tick goes through a memory read,
//    then the result register; a number goes through conversion, then
//    digit writes. The binary-to-BCD converter takes 4 bits per cycle and
//    the single write port of the byte store takes one digit per cycle.
//  - One command is processed at a time; req_tready is high while idle.
//  - A finished byte waits in the result register. If the receiver stalls,
//    writes continue; a later tick with a byte pending waits until the held beat is taken.
//  - Reset clears both indices and the result valid; the byte store is
//    not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tx_byte_buffer_with_decimal_writer_core #(
   parameter int BUFFER_DEPTH = tbw_pkg::BUFFER_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // [7:0] char_value, [39:8] number_value
   input  wire logic [2:0]  req_tuser,  // [2:0] operation
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata   // [7:0] tx_byte
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
   localparam int CNT_W = $clog2(tbw_pkg::CONV_CYCLES);
   localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(tbw_pkg::CONV_CYCLES - 1);

   // controller states
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_CONV    = 3'd1;
   localparam logic [2:0] ST_WRITE   = 3'd2;
   localparam logic [2:0] ST_READ    = 3'd3;
   localparam logic [2:0] ST_DELIVER = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic [CW-1:0]    send_ff, send_in;
   logic [31:0]      bin_ff, bin_in;
   logic [39:0]      bcd_ff, bcd_in;
   logic [CNT_W-1:0] conv_ff, conv_in;
   logic [3:0]       pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff;
   logic [7:0]       rd_ff;

   logic [7:0]  byte_store [BUFFER_DEPTH];

   logic        accept;
   logic [2:0]  op;
   logic [7:0]  char_value;
   logic [31:0] number_value;
   logic        num_ok;
   logic [3:0]  num_top;
   logic        has_room;
   logic        wr_en;
   logic [7:0]  wr_data;
   logic        rd_en;
   logic        load_rsp;
   logic [71:0] dabble;

   // four double-dabble steps on {bcd, bin}
   function automatic logic [71:0] dabble_step4(input logic [71:0] v);
      logic [71:0] t;
      t = v;
      for (int s = 0; s < tbw_pkg::CONV_BITS_PER_CYCLE; s++) begin
         for (int d = 0; d < 10; d++) begin
            if (t[32 + 4*d +: 4] >= 4'd5) begin
               t[32 + 4*d +: 4] = t[32 + 4*d +: 4] + 4'd3;
            end
         end
         t = t << 1;
      end
      return t;
   endfunction

   assign op           = req_tuser;
   assign char_value   = req_tdata[7:0];
   assign number_value = req_tdata[39:8];
   assign req_tready   = (state_ff == ST_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign has_room     = (fill_ff < DEPTH_C);
   assign dabble       = dabble_step4({bcd_ff, bin_ff});

   // number command decode
   always_comb begin
      num_ok  = 1'b0;
      num_top = tbw_pkg::TOP_POS_NUM10;
      case (op)
         tbw_pkg::OP_WRITE_NUM10: begin
            num_ok  = 1'b1;
            num_top = tbw_pkg::TOP_POS_NUM10;
         end
         tbw_pkg::OP_WRITE_NUM3: begin
            num_ok  = (number_value <= tbw_pkg::NUM3_MAX);
            num_top = tbw_pkg::TOP_POS_NUM3;
         end
         tbw_pkg::OP_WRITE_NUM2: begin
            num_ok  = (number_value <= tbw_pkg::NUM2_MAX);
            num_top = tbw_pkg::TOP_POS_NUM2;
         end
         default: begin
            num_ok  = 1'b0;
            num_top = tbw_pkg::TOP_POS_NUM10;
         end
      endcase
   end

   // controller
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      send_in  = send_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      conv_in  = conv_ff;
      pos_in   = pos_ff;
      wr_en    = 1'b0;
      wr_data  = char_value;
      rd_en    = 1'b0;
      load_rsp = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (op == tbw_pkg::OP_WRITE_CHAR) begin
                  wr_en   = has_room;
                  wr_data = char_value;
                  if (has_room) begin
                     fill_in = fill_ff + CW'(1);
                  end
               end else if (op == tbw_pkg::OP_TICK) begin
                  if (send_ff < fill_ff) begin
                     rd_en    = 1'b1;
                     send_in  = send_ff + CW'(1);
                     state_in = ST_READ;
                  end else begin
                     fill_in = '0;
                     send_in = '0;
                  end
               end else if (num_ok) begin
                  bin_in   = number_value;
                  bcd_in   = '0;
                  conv_in  = '0;
                  pos_in   = num_top;
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            bcd_in  = dabble[71:32];
            bin_in  = dabble[31:0];
            conv_in = conv_ff + CNT_W'(1);
            if (conv_ff == CONV_LAST) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // one digit per cycle, most significant first
            wr_en   = has_room;
            wr_data = tbw_pkg::ASCII_ZERO + {4'd0, bcd_ff[{pos_ff, 2'b00} +: 4]};
            if (has_room) begin
               fill_in = fill_ff + CW'(1);
            end
            pos_in = pos_ff - 4'd1;
            if (pos_ff == 4'd0) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         send_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         send_ff      <= send_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      conv_ff <= conv_in;
      pos_ff  <= pos_in;
      if (load_rsp) begin
         rsp_data_ff <= rd_ff;
      end
   end

   // byte store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         byte_store[fill_ff[AW-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= byte_store[send_ff[AW-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* src/tbw_checker.sv */
// ----------------------------------------------------------------------------
// tbw_checker: port-level checks for the transmit byte buffer
// Observes the command and result channels only.
// ----------------------------------------------------------------------------
`default_nettype none

module tbw_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [2:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata
);

   logic req_beat;
   assign req_beat = req_tvalid && req_tready;

   // a stalled result beat holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // no result beat appears in the cycle right after any command beat
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !$rose(rsp_tvalid))
      else $error("result beat appeared too early");

   // a char write leaves req_tready high again in the next cycle
   a_char_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_tuser == tbw_pkg::OP_WRITE_CHAR) |=> req_tready)
      else $error("char write did not finish in one cycle");

   // a ten-digit write always occupies the converter
   a_num10_busy: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_tuser == tbw_pkg::OP_WRITE_NUM10) |=> !req_tready)
      else $error("ten-digit write did not start conversion");

   // nothing valid on the result side right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind tx_byte_buffer_with_decimal_writer_core tbw_checker u_tbw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
